// File: rtl/core/hca_pkg.sv
// shared types, constants and register codes of the hybrid cellular automaton step
`timescale 1ns / 1ps

package hca_pkg;

  localparam int CELLS_MAX_DEF = 16;
  localparam int GEN_W         = 16;
  localparam int CNT_W         = 5;
  localparam int RULE_W        = 8;
  localparam int RULES_W       = 128;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 64;

  localparam logic [CFG_ADDR_W-1:0] REG_CELL_COUNT    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_LEFT_RADIUS   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_RADIUS  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_NULL_BOUNDARY = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_RULES_LOW     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_RULES_HIGH    = 3'd5;

  // static settings seen by every stage
  typedef struct packed {
    logic [CNT_W-1:0]   cell_n;    // clamped cell count
    logic [CNT_W-1:0]   shamt;     // cells_max minus cell_n
    logic               left_r;
    logic               right_r;
    logic               null_bnd;
    logic [RULES_W-1:0] rules;
  } cfg_t;

endpackage

// File: rtl/core/hca_align.sv
// stage 1: moves cell 0 of the present generation to the top bit
`timescale 1ns / 1ps

module hca_align #(
  parameter int CELLS_MAX = hca_pkg::CELLS_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hca_pkg::cfg_t              cfg,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [hca_pkg::GEN_W-1:0]  gen_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [CELLS_MAX-1:0]       cells_o
);

  logic                 valid_r;
  logic [CELLS_MAX-1:0] cells_r;
  logic [CELLS_MAX-1:0] cells_nxt;

  assign ready_o   = !valid_r || ready_i;
  // bits at or above the cell count fall off the top
  assign cells_nxt = gen_i[CELLS_MAX-1:0] << cfg.shamt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      cells_r <= cells_nxt;
    end
  end

  assign valid_o = valid_r;
  assign cells_o = cells_r;

endmodule

// File: rtl/core/hca_nbhd.sv
// stage 2: builds the three-bit neighborhood index of every cell
`timescale 1ns / 1ps

module hca_nbhd #(
  parameter int CELLS_MAX = hca_pkg::CELLS_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hca_pkg::cfg_t        cfg,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [CELLS_MAX-1:0] cells_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [2:0]           idx_o [CELLS_MAX]
);

  logic                 valid_r;
  logic [2:0]           idx_r   [CELLS_MAX];
  logic [2:0]           idx_nxt [CELLS_MAX];
  logic [CELLS_MAX-1:0] low_sh;
  logic                 wrap_l;
  logic                 wrap_r;

  assign ready_o = !valid_r || ready_i;

  // last cell in use sits at bit cells_max minus n, cell 0 at the top bit
  assign low_sh = cells_i >> cfg.shamt;
  assign wrap_l = cfg.null_bnd ? 1'b0 : low_sh[0];
  assign wrap_r = cfg.null_bnd ? 1'b0 : cells_i[CELLS_MAX-1];

  for (genvar i = 0; i < CELLS_MAX; i++) begin : g_cell
    logic lb;
    logic sb;
    logic rb;
    assign sb = cells_i[CELLS_MAX-1-i];
    if (i == 0) begin : g_left_edge
      assign lb = wrap_l;
    end else begin : g_left_in
      assign lb = cells_i[CELLS_MAX-i];
    end
    if (i == CELLS_MAX - 1) begin : g_right_edge
      assign rb = wrap_r;
    end else begin : g_right_in
      assign rb = (hca_pkg::CNT_W'(i + 1) >= cfg.cell_n) ? wrap_r : cells_i[CELLS_MAX-2-i];
    end
    always_comb begin
      case ({cfg.left_r, cfg.right_r})
        2'b11:   idx_nxt[i] = {lb, sb, rb};
        2'b10:   idx_nxt[i] = {1'b0, lb, sb};
        2'b01:   idx_nxt[i] = {1'b0, sb, rb};
        default: idx_nxt[i] = {2'b00, sb};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      idx_r <= idx_nxt;
    end
  end

  assign valid_o = valid_r;
  assign idx_o   = idx_r;

endmodule

// File: rtl/core/hca_rule.sv
// stage 3: looks up each cell's next state in its own rule
`timescale 1ns / 1ps

module hca_rule #(
  parameter int CELLS_MAX = hca_pkg::CELLS_MAX_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hca_pkg::cfg_t        cfg,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [2:0]           idx_i [CELLS_MAX],
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [CELLS_MAX-1:0] next_o
);

  logic                 valid_r;
  logic [CELLS_MAX-1:0] next_r;
  logic [CELLS_MAX-1:0] next_nxt;

  assign ready_o = !valid_r || ready_i;

  for (genvar i = 0; i < CELLS_MAX; i++) begin : g_cell
    logic [hca_pkg::RULE_W-1:0] rule;
    assign rule                   = cfg.rules[hca_pkg::RULE_W*i +: hca_pkg::RULE_W];
    assign next_nxt[CELLS_MAX-1-i] = rule[idx_i[i]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      next_r <= next_nxt;
    end
  end

  assign valid_o = valid_r;
  assign next_o  = next_r;

endmodule

// File: rtl/core/hca_unalign.sv
// stage 4: moves the next generation back to the low bits and holds the result
`timescale 1ns / 1ps

module hca_unalign #(
  parameter int CELLS_MAX = hca_pkg::CELLS_MAX_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hca_pkg::cfg_t             cfg,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [CELLS_MAX-1:0]      next_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [hca_pkg::GEN_W-1:0] gen_o
);

  logic                      valid_r;
  logic [hca_pkg::GEN_W-1:0] gen_r;
  logic [CELLS_MAX-1:0]      gen_sh;

  assign ready_o = !valid_r || ready_i;
  // cells beyond the count shift out, so unused high bits come out zero
  assign gen_sh  = next_i >> cfg.shamt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      gen_r <= hca_pkg::GEN_W'(gen_sh);
    end
  end

  assign valid_o = valid_r;
  assign gen_o   = gen_r;

endmodule

// File: rtl/core/hybrid_ca_next_generation.sv
// top level: one generation step of a hybrid one-dimensional cellular automaton
`timescale 1ns / 1ps

// Takes the present generation of up to CELLS_MAX binary cells (cell 0 in bit
// cell_count-1) and returns the next generation in the same bit order, with
// every bit at or above the cell count zero. Each cell has its own 8-bit rule
// indexed Wolfram style by {left, self, right}, the left and right neighbors
// taken only when their radius is 1, and edge neighbors read zero under a null
// boundary or wrap around the cells in use under a periodic one. A cell count
// above CELLS_MAX acts as CELLS_MAX; zero gives an all-zero result. The stages
// are align, neighborhood, rule lookup and output register, and one item is
// accepted every cycle unless a stall backs up to the input; each stage holds
// its own valid bit and only stops when it is full and the stage after it is
// stalled, so a waiting result does not block a new item while a bubble is
// free. Write configuration only while the pipeline is empty.

module hybrid_ca_next_generation #(
  parameter int CELLS_MAX = hca_pkg::CELLS_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [hca_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [hca_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // input items
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [hca_pkg::GEN_W-1:0]      in_tdata,   // [15:0] present_generation
  // result items
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [hca_pkg::GEN_W-1:0]      out_tdata   // [15:0] next_generation
);

  // configuration registers
  logic [hca_pkg::CNT_W-1:0]      cell_count_r;
  logic                           left_radius_r;
  logic                           right_radius_r;
  logic                           null_boundary_r;
  logic [hca_pkg::CFG_DATA_W-1:0] rules_low_r;
  logic [hca_pkg::CFG_DATA_W-1:0] rules_high_r;

  hca_pkg::cfg_t             cfg;
  logic [hca_pkg::CNT_W-1:0] cell_n;

  // pipeline links
  logic                 s1_valid;
  logic                 s1_ready;
  logic [CELLS_MAX-1:0] s1_cells;
  logic                 s2_valid;
  logic                 s2_ready;
  logic [2:0]           s2_idx [CELLS_MAX];
  logic                 s3_valid;
  logic                 s3_ready;
  logic [CELLS_MAX-1:0] s3_next;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_count_r    <= hca_pkg::CNT_W'(8);
      left_radius_r   <= 1'b1;
      right_radius_r  <= 1'b1;
      null_boundary_r <= 1'b1;
      rules_low_r     <= '0;
      rules_high_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        hca_pkg::REG_CELL_COUNT:    cell_count_r    <= cfg_wdata[hca_pkg::CNT_W-1:0];
        hca_pkg::REG_LEFT_RADIUS:   left_radius_r   <= cfg_wdata[0];
        hca_pkg::REG_RIGHT_RADIUS:  right_radius_r  <= cfg_wdata[0];
        hca_pkg::REG_NULL_BOUNDARY: null_boundary_r <= cfg_wdata[0];
        hca_pkg::REG_RULES_LOW:     rules_low_r     <= cfg_wdata;
        hca_pkg::REG_RULES_HIGH:    rules_high_r    <= cfg_wdata;
        default: ;  // unmapped index, write ignored
      endcase
    end
  end

  // clamp the cell count to the array size
  assign cell_n = (cell_count_r > hca_pkg::CNT_W'(CELLS_MAX)) ?
                  hca_pkg::CNT_W'(CELLS_MAX) : cell_count_r;

  assign cfg.cell_n   = cell_n;
  assign cfg.shamt    = hca_pkg::CNT_W'(CELLS_MAX) - cell_n;
  assign cfg.left_r   = left_radius_r;
  assign cfg.right_r  = right_radius_r;
  assign cfg.null_bnd = null_boundary_r;
  assign cfg.rules    = {rules_high_r, rules_low_r};

  hca_align #(.CELLS_MAX(CELLS_MAX)) u_align (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .valid_i (in_tvalid),
    .ready_o (in_tready),
    .gen_i   (in_tdata),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .cells_o (s1_cells)
  );

  hca_nbhd #(.CELLS_MAX(CELLS_MAX)) u_nbhd (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .cells_i (s1_cells),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .idx_o   (s2_idx)
  );

  hca_rule #(.CELLS_MAX(CELLS_MAX)) u_rule (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .idx_i   (s2_idx),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .next_o  (s3_next)
  );

  hca_unalign #(.CELLS_MAX(CELLS_MAX)) u_unalign (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .valid_i (s3_valid),
    .ready_o (s3_ready),
    .next_i  (s3_next),
    .valid_o (out_tvalid),
    .ready_i (out_tready),
    .gen_o   (out_tdata)
  );

endmodule

// File: tb/hca_step_checker.sv
// checker for the cellular automaton step: tracks registers, predicts each generation, compares
`timescale 1ns / 1ps

module hca_step_checker #(
  parameter int CELLS_MAX = hca_pkg::CELLS_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [hca_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [hca_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [hca_pkg::GEN_W-1:0]      in_tdata,   // [15:0] present_generation
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [hca_pkg::GEN_W-1:0]      out_tdata,  // [15:0] next_generation
  output int                             errors,
  output int                             pending
);

  // shadow copy of the block's registers
  logic [hca_pkg::CNT_W-1:0]   cell_cnt;
  logic                        left_r;
  logic                        right_r;
  logic                        null_bnd;
  logic [hca_pkg::RULES_W-1:0] rules;

  logic [hca_pkg::GEN_W-1:0] gen_expected [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic logic [hca_pkg::GEN_W-1:0] next_generation_of(
    input logic [hca_pkg::GEN_W-1:0] gen
  );
    int n;
    int i;
    logic [2:0] idx;
    logic nb;
    logic [hca_pkg::GEN_W-1:0] nxt;
    n   = (cell_cnt > CELLS_MAX) ? CELLS_MAX : int'(cell_cnt);
    nxt = '0;
    for (i = 0; i < n; i++) begin
      idx = '0;
      // cell k lives at bit n-1-k
      if (left_r) begin
        if (i == 0) nb = null_bnd ? 1'b0 : gen[0];
        else nb = gen[n-i];
        idx = {2'b00, nb};
      end
      idx = {idx[1:0], gen[n-1-i]};
      if (right_r) begin
        if (i + 1 >= n) nb = null_bnd ? 1'b0 : gen[n-1];
        else nb = gen[n-2-i];
        idx = {idx[1:0], nb};
      end
      nxt[n-1-i] = rules[8*i + int'(idx)];
    end
    return nxt;
  endfunction

  task automatic report_mismatch(input string what, input logic [hca_pkg::GEN_W-1:0] exp_v,
                                 input logic [hca_pkg::GEN_W-1:0] got_v);
    $display("%0t checker: %s expected %h got %h", $time, what, exp_v, got_v);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cell_cnt = hca_pkg::CNT_W'(8);
      left_r   = 1'b1;
      right_r  = 1'b1;
      null_bnd = 1'b1;
      rules    = '0;
      gen_expected.delete();
    end else begin
      if (in_tvalid && in_tready)
        gen_expected = {gen_expected, next_generation_of(in_tdata)};
      if (out_tvalid && out_tready) begin
        if (gen_expected.size() == 0)
          report_mismatch("next_generation with nothing expected", '0, out_tdata);
        else begin
          logic [hca_pkg::GEN_W-1:0] exp_gen;
          exp_gen = gen_expected.pop_front();
          if (out_tdata !== exp_gen)
            report_mismatch("next_generation", exp_gen, out_tdata);
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          hca_pkg::REG_CELL_COUNT:    cell_cnt = cfg_wdata[hca_pkg::CNT_W-1:0];
          hca_pkg::REG_LEFT_RADIUS:   left_r = cfg_wdata[0];
          hca_pkg::REG_RIGHT_RADIUS:  right_r = cfg_wdata[0];
          hca_pkg::REG_NULL_BOUNDARY: null_bnd = cfg_wdata[0];
          hca_pkg::REG_RULES_LOW:     rules[63:0] = cfg_wdata;
          hca_pkg::REG_RULES_HIGH:    rules[127:64] = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending = gen_expected.size();
  end

endmodule

// File: tb/testbench.sv
// top of the testbench: clock, reset, stimulus and verdict for the cellular automaton step
`timescale 1ns / 1ps

module testbench;

  localparam int HOLD_CYCLES = 300;     // long receiver hold-off to fill the pipeline
  localparam int CYCLE_LIMIT = 100000;  // far above the slowest correct run
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 100;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [hca_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [hca_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [hca_pkg::GEN_W-1:0]      in_tdata;   // [15:0] present_generation
  logic                           out_tvalid;
  logic                           out_tready;
  logic [hca_pkg::GEN_W-1:0]      out_tdata;  // [15:0] next_generation

  int          errors;
  int          pending;
  int unsigned cycle_cnt;

  // idling controls shared with the sender task and the receiver process
  logic tx_quiet;
  logic rx_quiet;
  logic hold_req;

  hybrid_ca_next_generation i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  hca_step_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .errors    (errors),
    .pending   (pending)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, a quiet mode, and one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= rx_quiet || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  // offer one item and wait until it is taken; sometimes idle first
  task automatic send_gen(input logic [hca_pkg::GEN_W-1:0] gen);
    if (!tx_quiet && $urandom_range(0, 99) < 10) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= gen;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering and let every outstanding result come out
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // a margin beyond the four-stage pipeline
    repeat (6) @(posedge clk);
  endtask

  // write all six registers back to back while the pipeline is empty
  task automatic load_config(input logic [hca_pkg::CNT_W-1:0] n, input logic l,
                             input logic r, input logic nb,
                             input logic [63:0] rl, input logic [63:0] rh);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= hca_pkg::REG_CELL_COUNT;
    cfg_wdata <= 64'(n);
    @(posedge clk);
    cfg_addr  <= hca_pkg::REG_LEFT_RADIUS;
    cfg_wdata <= 64'(l);
    @(posedge clk);
    cfg_addr  <= hca_pkg::REG_RIGHT_RADIUS;
    cfg_wdata <= 64'(r);
    @(posedge clk);
    cfg_addr  <= hca_pkg::REG_NULL_BOUNDARY;
    cfg_wdata <= 64'(nb);
    @(posedge clk);
    cfg_addr  <= hca_pkg::REG_RULES_LOW;
    cfg_wdata <= rl;
    @(posedge clk);
    cfg_addr  <= hca_pkg::REG_RULES_HIGH;
    cfg_wdata <= rh;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // cell count mix: mostly legal sizes, sometimes degenerate or oversized
  function automatic logic [hca_pkg::CNT_W-1:0] pick_cell_count();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return hca_pkg::CNT_W'($urandom_range(0, 2));
      1: return hca_pkg::CNT_W'($urandom_range(17, 31));
      2: return hca_pkg::CNT_W'(16);
      3: return hca_pkg::CNT_W'(3);
      default: return hca_pkg::CNT_W'($urandom_range(3, 16));
    endcase
  endfunction

  initial begin
    int ph;
    int k;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    tx_quiet  = 1'b0;
    rx_quiet  = 1'b0;
    hold_req  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    // reset settings: all rules zero, every result zero
    send_gen(16'hFFFF);
    send_gen(16'h00A5);
    // full width, null boundary, rule 30 everywhere
    load_config(5'd16, 1'b1, 1'b1, 1'b1, {8{8'h1E}}, {8{8'h1E}});
    send_gen(16'h0000);
    send_gen(16'hFFFF);
    send_gen(16'h8001);
    send_gen(16'hAAAA);
    // periodic wrap across the edges with mixed rules
    load_config(5'd16, 1'b1, 1'b1, 1'b0, rand64(), rand64());
    send_gen(16'h8001);
    send_gen(16'h5555);
    send_gen(16'hFFFF);
    // no neighbors: index is the cell alone
    load_config(5'd16, 1'b0, 1'b0, 1'b1, rand64(), rand64());
    send_gen(16'hFFFF);
    send_gen(16'h0000);
    // left neighbor only, small periodic ring, unused high input bits set
    load_config(5'd5, 1'b1, 1'b0, 1'b0, rand64(), rand64());
    send_gen(16'h001F);
    send_gen(16'hFFE0);
    // right neighbor only, smallest legal size
    load_config(5'd3, 1'b0, 1'b1, 1'b1, rand64(), rand64());
    send_gen(16'h0007);
    send_gen(16'h0005);
    // zero cells gives an all-zero result
    load_config(5'd0, 1'b1, 1'b1, 1'b0, '1, '1);
    send_gen(16'hFFFF);
    // oversized count acts as the maximum
    load_config(5'd31, 1'b1, 1'b1, 1'b0, rand64(), rand64());
    send_gen(16'hABCD);
    send_gen(16'h1234);
    // one cell: both neighbors are the cell itself when wrapping
    load_config(5'd1, 1'b1, 1'b1, 1'b0, rand64(), rand64());
    send_gen(16'h0001);
    send_gen(16'h0000);
    // two cells, null boundary, smaller than the neighborhood
    load_config(5'd2, 1'b1, 1'b1, 1'b1, rand64(), rand64());
    send_gen(16'h0003);
    send_gen(16'h0002);
    // all rules one
    load_config(5'd16, 1'b1, 1'b1, 1'b1, '1, '1);
    send_gen(16'h0000);

    // random part: a fresh configuration per phase
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_config(5'd16, 1'($urandom), 1'($urandom), 1'($urandom), rand64(), rand64());
        1: load_config(5'd3, 1'($urandom), 1'($urandom), 1'($urandom), rand64(), rand64());
        default: load_config(pick_cell_count(), 1'($urandom), 1'($urandom), 1'($urandom),
                             rand64(), rand64());
      endcase
      // one phase with no idling on either side
      tx_quiet = (ph == 3) || (ph == 6);
      rx_quiet = (ph == 3);
      // receiver holds off while the sender keeps offering
      if (ph == 6) hold_req = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++)
        send_gen(16'($urandom));
    end

    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    wait_idle();
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// File: hybrid_ca_next_generation.f
rtl/core/hca_pkg.sv
rtl/core/hca_align.sv
rtl/core/hca_nbhd.sv
rtl/core/hca_rule.sv
rtl/core/hca_unalign.sv
rtl/core/hybrid_ca_next_generation.sv
tb/hca_step_checker.sv
tb/testbench.sv
